>>> hdl/pqd_pkg.sv
// pqd_pkg: shared types and constants for the palette quantizer
// item and result payloads, the token that moves along the cell row
// no dependencies
package pqd_pkg;

  // default number of palette cells in the row
  localparam int PQD_DEPTH = 256;
  // width used to compare cell positions against counts and indexes
  localparam int PQD_POS_W = 11;
  // reciprocal of three in 11 fractional bits
  localparam logic [10:0] PQD_RECIP3 = 11'd683;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] entry_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } result_t;

  // one item in flight plus its running best match
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] entry_index;
    color_t     color;
    logic       found;
    logic [9:0] best;
    color_t     chosen;
  } token_t;

endpackage

>>> hdl/palette_quantize_desaturate.sv
// Palette quantizer with half desaturation. Every item enters a row of
// PALETTE_DEPTH cells, one cell per palette entry, and moves one cell per
// clock; a load item writes its cell as it passes, a pixel item keeps the
// nearest (L1) entry seen so far. One item is taken per clock whenever the
// result register is free or being read, and a pixel passes through the
// register of every cell in the row before its result is registered. A
// stall on the result side holds the whole row. The palette count
// register should only be written while no pixel is in the row.
module palette_quantize_desaturate import pqd_pkg::*; #(
  parameter int PALETTE_DEPTH = PQD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       palette_count_write,
  input  logic [8:0] palette_count_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  logic       advance;
  logic [8:0] palette_count;
  token_t     chain [0:PALETTE_DEPTH];

  // row moves whenever the result register can take the last cell's item
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  // palette count register
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= 9'd0;
    end else if (palette_count_write) begin
      palette_count <= palette_count_data;
    end
  end

  // item entering the row with no match yet
  always_comb begin
    chain[0].valid        = item_valid;
    chain[0].kind         = item.kind;
    chain[0].entry_index  = item.entry_index;
    chain[0].color.blue   = item.blue;
    chain[0].color.green  = item.green;
    chain[0].color.red    = item.red;
    chain[0].found        = 1'b0;
    chain[0].best         = 10'd0;
    chain[0].chosen       = '0;
  end

  // row of palette cells
  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pqd_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .palette_count(palette_count),
      .tok_in       (chain[i]),
      .tok_out      (chain[i+1])
    );
  end

  // blend and result register
  pqd_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .tok_in      (chain[PALETTE_DEPTH]),
    .result_valid(result_valid),
    .result      (result)
  );

`ifndef SYNTHESIS
  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a load leaving the row gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    advance && chain[PALETTE_DEPTH].valid && (chain[PALETTE_DEPTH].kind == KIND_LOAD)
    |=> !result_valid)
    else $error("load item produced a result");

  // blended channels never reach 255
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.blue_out != 8'hFF) && (result.green_out != 8'hFF) &&
                     (result.red_out != 8'hFF))
    else $error("blended channel out of range");
`endif

endmodule

>>> hdl/pqd_cell.sv
// pqd_cell: one palette entry of the row, matched against passing pixels
// loads write the entry when they reach the cell with the matching index
// depends on pqd_pkg
module pqd_cell import pqd_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [8:0] palette_count,
  input  token_t     tok_in,
  output token_t     tok_out
);

  color_t     entry;
  logic       hit_load;
  logic       in_range;
  logic [7:0] diff_b;
  logic [7:0] diff_g;
  logic [7:0] diff_r;
  logic [9:0] l1_dist;
  logic       take;
  token_t     tok_next;

  // load aimed at this cell
  assign hit_load = tok_in.valid && (tok_in.kind == KIND_LOAD) &&
                    ({3'b000, tok_in.entry_index} == PQD_POS_W'(CELL_INDEX));

  // cell takes part in matching only below the active count
  assign in_range = {2'b00, palette_count} > PQD_POS_W'(CELL_INDEX);

  // l1 distance between pixel and stored entry
  always_comb begin
    diff_b  = (entry.blue > tok_in.color.blue) ? entry.blue - tok_in.color.blue
                                               : tok_in.color.blue - entry.blue;
    diff_g  = (entry.green > tok_in.color.green) ? entry.green - tok_in.color.green
                                                 : tok_in.color.green - entry.green;
    diff_r  = (entry.red > tok_in.color.red) ? entry.red - tok_in.color.red
                                             : tok_in.color.red - entry.red;
    l1_dist = {2'b00, diff_b} + {2'b00, diff_g} + {2'b00, diff_r};
  end

  // strictly smaller wins, so ties stay with the lower index
  assign take = (tok_in.kind == KIND_PIXEL) && in_range &&
                (!tok_in.found || (l1_dist < tok_in.best));

  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.found  = 1'b1;
      tok_next.best   = l1_dist;
      tok_next.chosen = entry;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (advance && hit_load) begin
      entry <= tok_in.color;
    end
  end

  // hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> hdl/pqd_blend.sv
// pqd_blend: half desaturation of the chosen color and the result register
// gray level is the channel sum times a reciprocal of three
// depends on pqd_pkg
module pqd_blend import pqd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  token_t  tok_in,
  output logic    result_valid,
  output result_t result
);

  logic [9:0]  sum;
  logic [20:0] prod;
  logic [7:0]  gray;
  result_t     result_next;

  // gray = floor(sum / 3), exact for sums up to 765
  always_comb begin
    sum  = {2'b00, tok_in.chosen.blue} + {2'b00, tok_in.chosen.green} +
           {2'b00, tok_in.chosen.red};
    prod = {11'd0, sum} * {10'd0, PQD_RECIP3};
    gray = prod[18:11];
    result_next.blue_out  = {1'b0, tok_in.chosen.blue[7:1]} + {1'b0, gray[7:1]};
    result_next.green_out = {1'b0, tok_in.chosen.green[7:1]} + {1'b0, gray[7:1]};
    result_next.red_out   = {1'b0, tok_in.chosen.red[7:1]} + {1'b0, gray[7:1]};
  end

  // only pixel items leave a result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= tok_in.valid && (tok_in.kind == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule
